FILE: src/c2d_pkg.sv
package c2d_pkg;

  // default build values
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int PIXEL_BITS_DEF = 16;

  // fixed kernel geometry
  localparam int KERNEL_SIZE = 5;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES       = KERNEL_SIZE - 1;
  localparam int TAP_W       = $clog2(TAPS);

  // field widths
  localparam int WEIGHT_W = 16;
  localparam int DATA_W   = 16;
  localparam int SCALE_W  = 16;
  localparam int RESULT_W = 32;
  localparam int IWIDTH_W = 7;
  localparam int FRAC_W   = 15;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_FRAME_SIDE   = 1'b0;
  localparam logic REG_OUTPUT_SCALE = 1'b1;

  // register reset values
  localparam logic [IWIDTH_W-1:0]       FRAME_SIDE_RST   = 7'd32;
  localparam logic signed [SCALE_W-1:0] OUTPUT_SCALE_RST = 16'sd32767;

  // request operation codes
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [4:0]               weight_index;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] conv_value;
    logic                       end_of_map;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAC,
    ST_MAC_END,
    ST_SCALE,
    ST_OUT
  } state_t;

endpackage

FILE: src/conv2d_5x5_valid_scaled_unit.sv
// 5x5 valid convolution over a square image streamed in raster order.
// Input channel (in_valid/in_ready/in_item): a request either loads one
// weight (operation 0, tap index 0..24, larger indices are ignored) or
// delivers one pixel (operation 1). Output channel (out_valid/out_ready/
// out_item) carries the scaled, saturated window sum and a flag on the last
// result of each map. The APB port sets frame_side (0x0, restarts the
// frame) and output_scale (0x4); write it only while the block is idle.
// A weight request is taken while idle and the block stays idle; a pixel
// that completes no window passes a line memory read, then window shift
// and write back. A pixel that completes a window goes on through every
// tap in turn in the single shared multiply-accumulate, a step to close the
// sum, the scale multiply and the load of the output register. The block
// returns to idle as that register is loaded, so the next request can be
// taken while the result is presented. The output
// register holds a finished result while the receiver stalls; a further
// result waits in the block, with the input closed, until the register is
// free. Reset clears weights, window, counters and configuration registers
// to their defaults; unwritten line memory contents never reach a result.
module conv2d_5x5_valid_scaled_unit #(
  parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = c2d_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  c2d_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output c2d_pkg::out_item_t            out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [c2d_pkg::PADDR_W-1:0]   paddr,
  input  logic [c2d_pkg::PDATA_W-1:0]   pwdata,
  output logic [c2d_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import c2d_pkg::*;

  localparam int PW    = (PIXEL_BITS < DATA_W) ? PIXEL_BITS : DATA_W;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int XW    = (CW + 1 > IWIDTH_W) ? CW + 1 : IWIDTH_W;
  localparam int PRODW = PW + WEIGHT_W;
  localparam int SUM_W = PRODW + TAP_W;
  localparam int LW    = LINES * PW;

  state_t state, state_next;

  logic [IWIDTH_W-1:0]       frame_side;
  logic signed [SCALE_W-1:0] output_scale;

  logic signed [WEIGHT_W-1:0] weights [TAPS];
  logic signed [PW-1:0]       window [TAPS];
  logic [LW-1:0]              line_mem [MAX_WIDTH];
  logic [LW-1:0]              line_rd;

  logic [CW-1:0]          column_count;
  logic [CW-1:0]          row_count;
  logic signed [PW-1:0]   pixel;
  logic [TAP_W-1:0]       tap;
  logic                   prod_vld;
  logic signed [PRODW-1:0] prod;
  logic signed [SUM_W-1:0] acc;
  logic                   eom;

  logic                   in_take;
  logic                   cfg_wr;
  logic                   reg_idx;
  logic [XW-1:0]          width_x;
  logic [XW-1:0]          eff_width;
  logic [CW-1:0]          last_pos;
  logic                   emit;
  logic                   load_scale;
  logic                   load_out;
  logic signed [RESULT_W-1:0] scaled;

  assign in_take = in_valid && in_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  // effective image side, clamped to the supported range
  always_comb begin
    width_x = XW'(frame_side);
    if (width_x < XW'(KERNEL_SIZE)) begin
      eff_width = XW'(KERNEL_SIZE);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      eff_width = XW'(MAX_WIDTH);
    end else begin
      eff_width = width_x;
    end
    last_pos = CW'(eff_width - XW'(1));
  end

  assign emit = (row_count >= CW'(LINES)) && (column_count >= CW'(LINES));

  // register read back
  always_comb begin
    case (reg_idx)
      REG_FRAME_SIDE:   prdata = PDATA_W'(frame_side);
      REG_OUTPUT_SCALE: prdata = PDATA_W'($unsigned(output_scale));
      default:          prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_side   <= FRAME_SIDE_RST;
      output_scale <= OUTPUT_SCALE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_SIDE:   frame_side   <= pwdata[IWIDTH_W-1:0];
        REG_OUTPUT_SCALE: output_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_scale = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_item.operation == OP_PIXEL) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        state_next = emit ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        if (tap == TAP_W'(TAPS - 1)) begin
          state_next = ST_MAC_END;
        end
      end
      ST_MAC_END: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        load_scale = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // weight loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        weights[k] <= '0;
      end
    end else if (in_take && in_item.operation == OP_WEIGHT &&
                 in_item.weight_index < 5'(TAPS)) begin
      weights[in_item.weight_index[TAP_W-1:0]] <= in_item.data_value;
    end
  end

  // line memory: read the column on request, write back the shifted lines
  always_ff @(posedge clk) begin
    if (in_take && in_item.operation == OP_PIXEL) begin
      line_rd <= line_mem[column_count];
    end
    if (state == ST_SHIFT) begin
      line_mem[column_count] <= {pixel, line_rd[LW-1:PW]};
    end
  end

  // captured pixel
  always_ff @(posedge clk) begin
    if (in_take) begin
      pixel <= in_item.data_value[PW-1:0];
    end
  end

  // window shift by one column, new right column from the lines
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        window[k] <= '0;
      end
    end else if (state == ST_SHIFT) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
          window[i*KERNEL_SIZE + j] <= window[i*KERNEL_SIZE + j + 1];
        end
      end
      for (int i = 0; i < LINES; i++) begin
        window[i*KERNEL_SIZE + KERNEL_SIZE - 1] <= line_rd[i*PW +: PW];
      end
      window[TAPS - 1] <= pixel;
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_wr && reg_idx == REG_FRAME_SIDE) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (state == ST_SHIFT) begin
      if (column_count >= last_pos) begin
        column_count <= '0;
        row_count    <= (row_count >= last_pos) ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // last-of-map flag for the pending result
  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) begin
      eom <= (row_count == last_pos) && (column_count == last_pos);
    end
  end

  // multiply-accumulate, one tap a cycle with a registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      tap      <= '0;
      prod_vld <= 1'b0;
    end else begin
      case (state)
        ST_SHIFT: begin
          tap      <= '0;
          prod_vld <= 1'b0;
          acc      <= '0;
        end
        ST_MAC: begin
          prod     <= weights[tap] * window[tap];
          prod_vld <= 1'b1;
          tap      <= tap + TAP_W'(1);
          if (prod_vld) begin
            acc <= acc + SUM_W'(prod);
          end
        end
        ST_MAC_END: begin
          acc      <= acc + SUM_W'(prod);
          prod_vld <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  c2d_scale_sat #(
    .SUM_W   (SUM_W),
    .SCALE_W (SCALE_W),
    .FRAC_W  (FRAC_W),
    .RES_W   (RESULT_W)
  ) u_scale (
    .clk    (clk),
    .load   (load_scale),
    .sum    (acc),
    .scale  (output_scale),
    .result (scaled)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.conv_value <= scaled;
      out_item.end_of_map <= eom;
    end
  end

endmodule

FILE: src/c2d_scale_sat.sv
module c2d_scale_sat #(
  parameter int SUM_W   = 37,
  parameter int SCALE_W = 16,
  parameter int FRAC_W  = 15,
  parameter int RES_W   = 32
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [SUM_W-1:0]  sum,
  input  logic signed [SCALE_W-1:0] scale,
  output logic signed [RES_W-1:0]  result
);

  localparam int MW = SUM_W + SCALE_W;
  localparam int SW = (MW - FRAC_W > RES_W + 1) ? MW - FRAC_W : RES_W + 1;

  logic signed [MW-1:0] product;
  logic signed [SW-1:0] shifted;
  logic                 in_range;

  // registered scale multiply
  always_ff @(posedge clk) begin
    if (load) begin
      product <= sum * scale;
    end
  end

  // drop fraction bits (floor), then clamp to the result range
  always_comb begin
    shifted  = SW'(product >>> FRAC_W);
    in_range = (&shifted[SW-1:RES_W-1]) | ~(|shifted[SW-1:RES_W-1]);
    if (in_range) begin
      result = shifted[RES_W-1:0];
    end else if (shifted[SW-1]) begin
      result = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

endmodule
